>>> hw/rtl/lpt_pkg.sv
`default_nettype none

package lpt_pkg;

    // Defaults for the top-level storage parameters
    localparam int MAX_LAYERS_DEF = 64;
    localparam int MAX_LEVELS_DEF = 8;

    // Cost format: unsigned fixed point
    localparam int COST_FRAC_BITS = 16;
    localparam int COST_W         = 64;

    // Stream and storage widths
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 72;
    localparam int DIMS_W    = 112;
    localparam int HCNT_W    = 6;
    localparam int HV_W      = 3 * HCNT_W;
    localparam int ROW_W     = 6;
    localparam int PROD_W    = 56;
    localparam int DOWN_W    = 7;

    localparam logic [HCNT_W-1:0] HCNT_MAX = '1;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_PART = 2'd1,
        KIND_COST = 2'd2
    } kind_t;

    // Partition types; the fourth term code is the link cost
    typedef logic [1:0] ptype_t;
    localparam ptype_t TYPE_ROW  = 2'd0;
    localparam ptype_t TYPE_CIN  = 2'd1;
    localparam ptype_t TYPE_COUT = 2'd2;
    localparam ptype_t TERM_LINK = 2'd3;

    // Register map (word index)
    localparam logic [1:0] REG_LAYER_COUNT   = 2'd0;
    localparam logic [1:0] REG_LEVEL_COUNT   = 2'd1;
    localparam logic [1:0] REG_TYPE_COUNT    = 2'd2;
    localparam logic [1:0] REG_SHORTCUT_MODE = 2'd3;

    // Shortcut modes
    localparam logic [1:0] SC_NONE  = 2'd0;
    localparam logic [1:0] SC_TWO   = 2'd1;
    localparam logic [1:0] SC_THREE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RESP,
        ST_FETCH,
        ST_TERM,
        ST_L0,
        ST_CAND,
        ST_COMMIT,
        ST_ROW,
        ST_FIN,
        ST_TB_RD,
        ST_TB_WR
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  li;
        logic [2:0]  hi;
        logic [15:0] batch;
        logic [15:0] cin;
        logic [15:0] cout;
        logic [15:0] karea;
        logic [23:0] in_area;
        logic [23:0] out_area;
    } item_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       ld_wr;
        logic       fetch;
        logic       term_go;
        ptype_t     term_sel;
        logic       lvl0;
        logic       l0_init;
        logic       cand;
        logic       cand_first;
        ptype_t     t;
        ptype_t     p;
        logic       sc;
        logic       mode2;
        logic       commit;
        logic       row;
        logic       fin;
        logic       fin_first;
        logic       tb_rd;
        logic       tb_wr;
        logic       lc_wr;
        logic       rd_issue;
        logic       out_load;
        logic       ok;
        logic       is_part;
        logic [5:0] li;
        logic [2:0] hi;
    } cmd_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? '1 : s[COST_W-1:0];
    endfunction

    // Pairs of types that need no redistribution
    function automatic logic link_free(input ptype_t a, input ptype_t b);
        return (a == TYPE_ROW && b == TYPE_ROW) || (a == TYPE_CIN && b == TYPE_COUT) ||
               (a == TYPE_COUT && b == TYPE_CIN);
    endfunction

    function automatic ptype_t mod3(input ptype_t v);
        return (v == TERM_LINK) ? TYPE_ROW : v;
    endfunction

    function automatic ptype_t row_get(input logic [ROW_W-1:0] row, input ptype_t idx);
        ptype_t r;
        case (idx)
            TYPE_ROW:  r = row[1:0];
            TYPE_CIN:  r = row[3:2];
            TYPE_COUT: r = row[5:4];
            default:   r = TYPE_ROW;
        endcase
        return r;
    endfunction

    // Scale the product to fixed point, truncate, saturate
    function automatic logic [COST_W-1:0] scale_cost(input logic [PROD_W-1:0] v,
                                                     input logic [DOWN_W-1:0] down);
        logic [127:0] w;
        w = 128'(v) << COST_FRAC_BITS;
        w = w >> down;
        return (w[127:COST_W] != '0) ? '1 : w[COST_W-1:0];
    endfunction

    // Add one halving to the field of the chosen type, saturating
    function automatic logic [HV_W-1:0] hv_bump(input logic [HV_W-1:0] hv, input ptype_t w);
        logic [HV_W-1:0] r;
        r = hv;
        case (w)
            TYPE_ROW:
                if (hv[5:0] != HCNT_MAX) r[5:0] = hv[5:0] + 6'd1;
            TYPE_CIN:
                if (hv[11:6] != HCNT_MAX) r[11:6] = hv[11:6] + 6'd1;
            TYPE_COUT:
                if (hv[17:12] != HCNT_MAX) r[17:12] = hv[17:12] + 6'd1;
            default: r = hv;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/layer_partition_trellis_dp.sv
// Layer partition optimiser. Load layer descriptions with kind 0 words, set the
// counts over the APB port, then read a chosen partition type (kind 1) or a level
// cost (kind 2). A read uses the stored results when they are current; the first
// read after any in-range load or register write first runs the solve. The solve
// works one layer at a time through a single two-stage cost multiplier and one
// candidate compare per cycle. The input stays stalled during a solve.
`default_nettype none

module layer_partition_trellis_dp #(
    parameter int MAX_LAYERS = lpt_pkg::MAX_LAYERS_DEF,
    parameter int MAX_LEVELS = lpt_pkg::MAX_LEVELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // layer_index, level_index, batch, channels_in, channels_out,
    // kernel_area, in_map_area, out_map_area
    input  wire logic [lpt_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // partition_type, level_cost
    output logic [lpt_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [0:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import lpt_pkg::*;

    localparam int LW = $clog2(MAX_LAYERS);
    localparam int HW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    item_t         item;
    cmd_t          cmd;
    logic [LW-1:0] lay_idx;
    logic [HW-1:0] lvl_idx;

    // Unpack the input word
    assign item.kind     = s_tuser;
    assign item.li       = s_tdata[5:0];
    assign item.hi       = s_tdata[8:6];
    assign item.batch    = s_tdata[24:9];
    assign item.cin      = s_tdata[40:25];
    assign item.cout     = s_tdata[56:41];
    assign item.karea    = s_tdata[72:57];
    assign item.in_area  = s_tdata[96:73];
    assign item.out_area = s_tdata[120:97];

    lpt_ctrl #(.MAX_LAYERS(MAX_LAYERS), .MAX_LEVELS(MAX_LEVELS), .LW(LW), .HW(HW)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item     (item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cmd      (cmd),
        .lay_idx  (lay_idx),
        .lvl_idx  (lvl_idx)
    );

    lpt_dp #(.MAX_LAYERS(MAX_LAYERS), .MAX_LEVELS(MAX_LEVELS), .LW(LW), .HW(HW)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .cmd     (cmd),
        .lay_idx (lay_idx),
        .lvl_idx (lvl_idx),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lpt_ram.sv
`default_nettype none

module lpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lpt_ctrl.sv
`default_nettype none

module lpt_ctrl #(
    parameter int MAX_LAYERS = lpt_pkg::MAX_LAYERS_DEF,
    parameter int MAX_LEVELS = lpt_pkg::MAX_LEVELS_DEF,
    parameter int LW = $clog2(MAX_LAYERS),
    parameter int HW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire lpt_pkg::item_t item,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output lpt_pkg::cmd_t       cmd,
    output logic [LW-1:0]       lay_idx,
    output logic [HW-1:0]       lvl_idx
);

    import lpt_pkg::*;

    state_t      state_reg, state_next;
    logic [6:0]  layer_count_reg;
    logic [3:0]  level_count_reg;
    logic [1:0]  type_count_reg;
    logic [1:0]  shortcut_mode_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [5:0]  li_reg, li_next;
    logic [2:0]  hi_reg, hi_next;
    logic        ready_reg, ready_next;
    logic        out_valid_reg, out_valid_next;
    logic [LW-1:0] lay_reg, lay_next;
    logic [HW-1:0] lvl_reg, lvl_next;
    logic [1:0]  mod3_reg, mod3_next;
    ptype_t      t_reg, t_next;
    ptype_t      p_reg, p_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic          accept;
    logic          cfg_wr;
    logic [LW-1:0] last_lay;
    logic [HW-1:0] last_lvl;
    ptype_t        ntm1;
    logic [1:0]    mode_eff;
    logic          sc;
    logic          lay_ok;
    logic          lvl_ok;

    assign accept   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign lay_idx  = lay_reg;
    assign lvl_idx  = lvl_reg;

    // Clamp the counts to the storage limits
    always_comb begin
        if (layer_count_reg == '0) begin
            last_lay = '0;
        end else if (32'(layer_count_reg) > MAX_LAYERS) begin
            last_lay = LW'(MAX_LAYERS - 1);
        end else begin
            last_lay = LW'(layer_count_reg - 7'd1);
        end
        if (level_count_reg == '0) begin
            last_lvl = '0;
        end else if (32'(level_count_reg) > MAX_LEVELS) begin
            last_lvl = HW'(MAX_LEVELS - 1);
        end else begin
            last_lvl = HW'(level_count_reg - 4'd1);
        end
    end

    assign ntm1     = (type_count_reg == 2'd3) ? TYPE_COUT : TYPE_CIN;
    assign mode_eff = (type_count_reg == 2'd3 && shortcut_mode_reg != 2'd3) ?
                      shortcut_mode_reg : SC_NONE;
    assign sc       = (mode_eff == SC_TWO && 32'(lay_reg) > 2 && lay_reg[0]) ||
                      (mode_eff == SC_THREE && 32'(lay_reg) > 3 && mod3_reg == 2'd1);
    assign lay_ok   = 32'(li_reg) <= 32'(last_lay);
    assign lvl_ok   = 32'(hi_reg) <= 32'(last_lvl);

    // Register read-back
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_LAYER_COUNT:   prdata = 32'(layer_count_reg);
            REG_LEVEL_COUNT:   prdata = 32'(level_count_reg);
            REG_TYPE_COUNT:    prdata = 32'(type_count_reg);
            REG_SHORTCUT_MODE: prdata = 32'(shortcut_mode_reg);
        endcase
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        li_next        = li_reg;
        hi_next        = hi_reg;
        ready_next     = ready_reg;
        lay_next       = lay_reg;
        lvl_next       = lvl_reg;
        mod3_next      = mod3_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.li         = li_reg;
        cmd.hi         = hi_reg;
        cmd.t          = t_reg;
        cmd.p          = p_reg;
        cmd.sc         = sc;
        cmd.mode2      = (mode_eff == SC_THREE);
        cmd.lvl0       = (lvl_reg == '0);
        cmd.is_part    = (kind_reg == KIND_PART);
        cmd.ok         = (kind_reg == KIND_PART) ? (lay_ok && lvl_ok) : lvl_ok;
        cmd.term_sel   = ptype_t'(cnt_reg[1:0]);
        cmd.cand_first = (p_reg == TYPE_ROW);
        cmd.fin_first  = (t_reg == TYPE_ROW);

        if (cfg_wr) begin
            ready_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next = item.kind;
                    li_next   = item.li;
                    hi_next   = item.hi;
                    case (item.kind) inside
                        KIND_LOAD: begin
                            if (32'(item.li) < MAX_LAYERS) begin
                                cmd.ld_wr  = 1'b1;
                                ready_next = 1'b0;
                            end
                        end
                        KIND_PART, KIND_COST: begin
                            if (ready_reg) begin
                                state_next = ST_RD_ISSUE;
                            end else begin
                                lvl_next   = '0;
                                lay_next   = '0;
                                mod3_next  = '0;
                                state_next = ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                cnt_next   = '0;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                // Issue four terms, then drain the multiplier pipeline
                cmd.term_go = (cnt_reg < 3'd4);
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    t_next     = TYPE_ROW;
                    p_next     = TYPE_ROW;
                    state_next = (lay_reg == '0) ? ST_L0 : ST_CAND;
                end
            end
            ST_L0: begin
                cmd.l0_init = 1'b1;
                state_next  = ST_ROW;
            end
            ST_CAND: begin
                cmd.cand = 1'b1;
                if (p_reg == ntm1) begin
                    state_next = ST_COMMIT;
                end else begin
                    p_next = p_reg + 2'd1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                p_next     = TYPE_ROW;
                if (t_reg == ntm1) begin
                    state_next = ST_ROW;
                end else begin
                    t_next     = t_reg + 2'd1;
                    state_next = ST_CAND;
                end
            end
            ST_ROW: begin
                cmd.row = 1'b1;
                if (lay_reg == last_lay) begin
                    t_next     = TYPE_ROW;
                    state_next = ST_FIN;
                end else begin
                    lay_next   = lay_reg + LW'(1);
                    mod3_next  = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                    state_next = ST_FETCH;
                end
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                if (t_reg == ntm1) begin
                    state_next = ST_TB_RD;
                end else begin
                    t_next = t_reg + 2'd1;
                end
            end
            ST_TB_RD: begin
                cmd.tb_rd  = 1'b1;
                cmd.lc_wr  = (lay_reg == last_lay);
                state_next = ST_TB_WR;
            end
            ST_TB_WR: begin
                cmd.tb_wr = 1'b1;
                if (lay_reg == '0) begin
                    if (lvl_reg == last_lvl) begin
                        ready_next = 1'b1;
                        state_next = ST_RD_ISSUE;
                    end else begin
                        lvl_next   = lvl_reg + HW'(1);
                        mod3_next  = '0;
                        state_next = ST_FETCH;
                    end
                end else begin
                    lay_next   = lay_reg - LW'(1);
                    state_next = ST_TB_RD;
                end
            end
            ST_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                // Hold until the output word is free
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            layer_count_reg   <= 7'd1;
            level_count_reg   <= 4'd1;
            type_count_reg    <= 2'd3;
            shortcut_mode_reg <= SC_NONE;
            kind_reg          <= '0;
            li_reg            <= '0;
            hi_reg            <= '0;
            ready_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            lay_reg           <= '0;
            lvl_reg           <= '0;
            mod3_reg          <= '0;
            t_reg             <= TYPE_ROW;
            p_reg             <= TYPE_ROW;
            cnt_reg           <= '0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            li_reg        <= li_next;
            hi_reg        <= hi_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            lay_reg       <= lay_next;
            lvl_reg       <= lvl_next;
            mod3_reg      <= mod3_next;
            t_reg         <= t_next;
            p_reg         <= p_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_LAYER_COUNT:   layer_count_reg   <= pwdata[6:0];
                    REG_LEVEL_COUNT:   level_count_reg   <= pwdata[3:0];
                    REG_TYPE_COUNT:    type_count_reg    <= pwdata[1:0];
                    REG_SHORTCUT_MODE: shortcut_mode_reg <= pwdata[1:0];
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lpt_dp.sv
`default_nettype none

module lpt_dp #(
    parameter int MAX_LAYERS = lpt_pkg::MAX_LAYERS_DEF,
    parameter int MAX_LEVELS = lpt_pkg::MAX_LEVELS_DEF,
    parameter int LW = $clog2(MAX_LAYERS),
    parameter int HW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire lpt_pkg::item_t item,
    input  wire lpt_pkg::cmd_t  cmd,
    input  wire logic [LW-1:0]  lay_idx,
    input  wire logic [HW-1:0]  lvl_idx,
    output logic [lpt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]          m_tuser
);

    import lpt_pkg::*;

    localparam int CT_DEPTH = 2 ** (LW + HW);

    logic [DIMS_W-1:0] dims_rd;
    logic [HV_W-1:0]   hv_rd;
    logic [HV_W-1:0]   hv_cur;
    logic [HV_W-1:0]   hv_upd;
    logic [ROW_W-1:0]  bp_rd;
    ptype_t            ct_rd;

    // Term pipeline
    logic [15:0]       d1, d2;
    logic [23:0]       area;
    logic [DOWN_W-1:0] down;
    logic [31:0]       p12_reg;
    logic [23:0]       area_reg;
    logic [DOWN_W-1:0] down1_reg, down2_reg;
    ptype_t            w1_reg, w2_reg;
    logic              v1_reg, v2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [COST_W-1:0] term_reg [4];

    // Trellis state
    logic [COST_W-1:0] pc_reg [3];
    logic [COST_W-1:0] pcn_reg [3];
    ptype_t            bpn_reg [3];
    logic [ROW_W-1:0]  bp1_reg, bp2_reg;
    logic [COST_W-1:0] best_reg;
    ptype_t            sel_reg;
    logic [COST_W-1:0] lc_reg [MAX_LEVELS];

    logic [COST_W-1:0] x_cost, lk, scl, c_plain, c_full;
    ptype_t            pp1, pp;

    logic [1:0]        part_reg;
    logic [COST_W-1:0] cost_reg;
    logic              status_reg;

    lpt_ram #(.WIDTH(DIMS_W), .DEPTH(MAX_LAYERS)) u_dims (
        .aclk  (aclk),
        .we    (cmd.ld_wr),
        .waddr (LW'(item.li)),
        .wdata ({item.out_area, item.in_area, item.karea, item.cout, item.cin, item.batch}),
        .re    (cmd.fetch),
        .raddr (lay_idx),
        .rdata (dims_rd)
    );

    lpt_ram #(.WIDTH(HV_W), .DEPTH(MAX_LAYERS)) u_hv (
        .aclk  (aclk),
        .we    (cmd.tb_wr),
        .waddr (lay_idx),
        .wdata (hv_upd),
        .re    (cmd.fetch || cmd.tb_rd),
        .raddr (lay_idx),
        .rdata (hv_rd)
    );

    lpt_ram #(.WIDTH(ROW_W), .DEPTH(MAX_LAYERS)) u_bp (
        .aclk  (aclk),
        .we    (cmd.row),
        .waddr (lay_idx),
        .wdata ({bpn_reg[2], bpn_reg[1], bpn_reg[0]}),
        .re    (cmd.tb_rd),
        .raddr (lay_idx),
        .rdata (bp_rd)
    );

    lpt_ram #(.WIDTH(2), .DEPTH(CT_DEPTH)) u_ct (
        .aclk  (aclk),
        .we    (cmd.tb_wr),
        .waddr ({lvl_idx, lay_idx}),
        .wdata (sel_reg),
        .re    (cmd.rd_issue),
        .raddr ({HW'(cmd.hi), LW'(cmd.li)}),
        .rdata (ct_rd)
    );

    // Halvings count from zero on the first level
    assign hv_cur = cmd.lvl0 ? '0 : hv_rd;
    assign hv_upd = hv_bump(hv_cur, sel_reg);

    // Select the operands of one cost term
    always_comb begin
        d1   = dims_rd[31:16];
        d2   = dims_rd[47:32];
        area = {8'd0, dims_rd[63:48]};
        down = {1'b0, hv_cur[11:6]} + {1'b0, hv_cur[17:12]};
        unique case (cmd.term_sel)
            TYPE_ROW: ;
            TYPE_CIN: begin
                d1   = dims_rd[15:0];
                area = dims_rd[111:88];
                down = {1'b0, hv_cur[5:0]} + {1'b0, hv_cur[17:12]};
            end
            TYPE_COUT: begin
                d1   = dims_rd[15:0];
                d2   = dims_rd[31:16];
                area = dims_rd[87:64];
                down = {1'b0, hv_cur[5:0]} + {1'b0, hv_cur[11:6]};
            end
            TERM_LINK: begin
                d1   = dims_rd[15:0];
                d2   = dims_rd[31:16];
                area = dims_rd[87:64];
                down = {1'b0, hv_cur[5:0]} + {1'b0, hv_cur[11:6]} + 7'd1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.term_go;
            v2_reg <= v1_reg;
        end
    end

    // Multiply in two stages, then scale
    always_ff @(posedge aclk) begin
        p12_reg   <= d1 * d2;
        area_reg  <= area;
        down1_reg <= down;
        w1_reg    <= cmd.term_sel;
        prod_reg  <= p12_reg * area_reg;
        down2_reg <= down1_reg;
        w2_reg    <= w1_reg;
        if (v2_reg) begin
            term_reg[w2_reg] <= scale_cost(prod_reg, down2_reg);
        end
    end

    // Candidate through previous type p into type t
    assign x_cost  = term_reg[TERM_LINK];
    assign lk      = link_free(cmd.p, cmd.t) ? '0 : x_cost;
    assign c_plain = sat_add(pc_reg[cmd.p], lk);
    assign pp1     = mod3(row_get(bp1_reg, cmd.p));
    assign pp      = cmd.mode2 ? mod3(row_get(bp2_reg, pp1)) : pp1;
    assign scl     = (cmd.sc && !link_free(pp, cmd.t)) ? x_cost : '0;
    assign c_full  = sat_add(c_plain, scl);

    always_ff @(posedge aclk) begin
        if (cmd.cand) begin
            if (cmd.cand_first) begin
                best_reg <= c_plain;
                sel_reg  <= TYPE_ROW;
            end else if (best_reg > c_full) begin
                best_reg <= c_full;
                sel_reg  <= cmd.p;
            end
        end
        if (cmd.fin) begin
            if (cmd.fin_first) begin
                best_reg <= pc_reg[TYPE_ROW];
                sel_reg  <= TYPE_ROW;
            end else if (best_reg > pc_reg[cmd.t]) begin
                best_reg <= pc_reg[cmd.t];
                sel_reg  <= cmd.t;
            end
        end
        // Step back along the track table
        if (cmd.tb_wr) begin
            sel_reg <= mod3(row_get(bp_rd, sel_reg));
        end
        if (cmd.commit) begin
            pcn_reg[cmd.t] <= sat_add(term_reg[cmd.t], best_reg);
            bpn_reg[cmd.t] <= sel_reg;
        end
        if (cmd.l0_init) begin
            for (int i = 0; i < 3; i++) begin
                pcn_reg[i] <= term_reg[i];
                bpn_reg[i] <= ptype_t'(i);
            end
        end
        // Advance the trellis by one layer
        if (cmd.row) begin
            for (int i = 0; i < 3; i++) begin
                pc_reg[i] <= pcn_reg[i];
            end
            bp2_reg <= bp1_reg;
            bp1_reg <= {bpn_reg[2], bpn_reg[1], bpn_reg[0]};
        end
        if (cmd.lc_wr) begin
            lc_reg[lvl_idx] <= best_reg;
        end
        // Result word
        if (cmd.out_load) begin
            part_reg   <= (cmd.is_part && cmd.ok) ? ct_rd : TYPE_ROW;
            cost_reg   <= (!cmd.is_part && cmd.ok) ? lc_reg[HW'(cmd.hi)] : '0;
            status_reg <= !cmd.ok;
        end
    end

    assign m_tdata = {6'd0, cost_reg, part_reg};
    assign m_tuser = status_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lpt_chk.sv
`default_nettype none

module lpt_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [127:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // Drop the result word on reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    // An error result carries zero fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 72'd0)
        else $error("error result carries data");

    // Only three partition types exist
    a_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("invalid partition type");

    // A cost result carries no partition type
    a_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65:2] != 64'd0 |-> m_tdata[1:0] == 2'd0)
        else $error("cost and type in one word");

endmodule

bind layer_partition_trellis_dp lpt_chk u_lpt_chk (.*);

`default_nettype wire
